/* rtl/core/fcis_pkg.sv */
// Shared types, constants and clamp helpers for the flight control input shaper.
`timescale 1ns / 1ps

package fcis_pkg;

    localparam int PITCH_W    = 11;
    localparam int ROLL_W     = 12;
    localparam int AXIS_W     = 9;
    localparam int THROTTLE_W = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 40;

    localparam int AXIS_STEP      = 5;
    localparam int THROTTLE_STEP  = 2;
    localparam int AXIS_LIMIT     = 200;
    localparam int THROTTLE_LIMIT = 200;

    localparam logic [PITCH_W-1:0] TARGET_PITCH_RESET = PITCH_W'(40);
    localparam logic [ROLL_W-1:0]  TARGET_ROLL_RESET  = ROLL_W'(0);

    // ceil(2^17 / 3): exact floor(m / 3) for m below 2^16
    localparam logic [15:0] DIV3_RECIP = 16'hAAAB;
    localparam int          DIV3_SHIFT = 17;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AUTOPILOT_ENABLE = 2'd0,
        CFG_TARGET_PITCH     = 2'd1,
        CFG_TARGET_ROLL      = 2'd2
    } cfg_index_t;

    // Input item, last field in the lowest bits
    typedef struct packed {
        logic signed [ROLL_W-1:0]  roll_tenths;
        logic signed [PITCH_W-1:0] pitch_tenths;
        logic                      other_key_held;
        logic                      key_throttle_down;
        logic                      key_throttle_up;
        logic                      key_yaw_minus;
        logic                      key_yaw_plus;
        logic                      key_roll_right;
        logic                      key_roll_left;
        logic                      key_pitch_down;
        logic                      key_up;
    } in_item_t;

    // Key pair for one control axis; the first key wins when both are held
    typedef struct packed {
        logic first;
        logic second;
        logic first_down;
    } axis_keys_t;

    function automatic logic signed [AXIS_W-1:0] clamp_axis(input logic signed [15:0] v);
        logic signed [15:0] lim;
        lim = 16'(AXIS_LIMIT);
        if (v < -lim) begin
            return -lim[AXIS_W-1:0];
        end else if (v > lim) begin
            return lim[AXIS_W-1:0];
        end
        return v[AXIS_W-1:0];
    endfunction

    function automatic logic [THROTTLE_W-1:0] clamp_throttle(input logic signed [9:0] v);
        logic signed [9:0] lim;
        lim = 10'(THROTTLE_LIMIT);
        if (v < 10'sd0) begin
            return '0;
        end else if (v > lim) begin
            return lim[THROTTLE_W-1:0];
        end
        return v[THROTTLE_W-1:0];
    endfunction

endpackage

/* rtl/core/fcis_axis.sv */
// One control axis: ramp while a key is held, otherwise return toward zero.
`timescale 1ns / 1ps

module fcis_axis (
    input  fcis_pkg::axis_keys_t                keys,
    input  logic signed [fcis_pkg::AXIS_W-1:0]  pos,
    output logic signed [fcis_pkg::AXIS_W-1:0]  pos_next
);
    import fcis_pkg::*;

    logic signed [AXIS_W:0] pos_ext;
    logic signed [AXIS_W:0] step;
    logic signed [AXIS_W:0] step_first;
    logic signed [AXIS_W:0] sum;

    assign pos_ext    = {pos[AXIS_W-1], pos};
    assign step       = (AXIS_W+1)'(AXIS_STEP);
    assign step_first = keys.first_down ? -step : step;

    always_comb begin
        if (keys.first) begin
            sum = pos_ext + step_first;
        end else if (keys.second) begin
            sum = pos_ext - step_first;
        end else if (pos_ext < -step) begin
            sum = pos_ext + step;
        end else if (pos_ext > step) begin
            sum = pos_ext - step;
        end else begin
            // snap to center once within one step
            sum = '0;
        end
    end

    assign pos_next = clamp_axis({{(15-AXIS_W){sum[AXIS_W]}}, sum});

endmodule

/* rtl/core/fcis_autopilot.sv */
// Autopilot commands from attitude error: elevator from pitch, aileron from roll.
`timescale 1ns / 1ps

module fcis_autopilot (
    input  logic signed [fcis_pkg::PITCH_W-1:0] pitch_tenths,
    input  logic signed [fcis_pkg::ROLL_W-1:0]  roll_tenths,
    input  logic signed [fcis_pkg::PITCH_W-1:0] target_pitch,
    input  logic signed [fcis_pkg::ROLL_W-1:0]  target_roll,
    output logic signed [fcis_pkg::AXIS_W-1:0]  elevator_cmd,
    output logic signed [fcis_pkg::AXIS_W-1:0]  aileron_cmd
);
    import fcis_pkg::*;

    logic signed [PITCH_W:0]  pitch_err;
    logic signed [ROLL_W:0]   roll_err;
    logic                     roll_neg;
    logic        [ROLL_W:0]   roll_mag;
    logic        [ROLL_W+1:0] roll_mag2;
    logic        [ROLL_W+17:0] prod;
    logic        [ROLL_W:0]   quo;
    logic signed [ROLL_W+1:0] aileron_raw;

    assign pitch_err = {pitch_tenths[PITCH_W-1], pitch_tenths}
                     - {target_pitch[PITCH_W-1], target_pitch};
    assign roll_err  = {target_roll[ROLL_W-1], target_roll}
                     - {roll_tenths[ROLL_W-1], roll_tenths};

    // divide the doubled magnitude by three, then restore the sign (truncates toward zero)
    assign roll_neg    = roll_err[ROLL_W];
    assign roll_mag    = roll_neg ? (ROLL_W+1)'(-roll_err) : roll_err;
    assign roll_mag2   = {roll_mag, 1'b0};
    assign prod        = roll_mag2 * DIV3_RECIP;
    assign quo         = prod[DIV3_SHIFT +: ROLL_W+1];
    assign aileron_raw = roll_neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

    assign elevator_cmd = clamp_axis({{(15-PITCH_W){pitch_err[PITCH_W]}}, pitch_err});
    assign aileron_cmd  = clamp_axis({{(14-ROLL_W){aileron_raw[ROLL_W+1]}}, aileron_raw});

endmodule

/* rtl/core/flight_control_input_shaper_core.sv */
// Flight control input shaper: input register, one-pass update, result/state register.
//
// Takes one tick per transfer and returns one result per tick with the elevator, aileron,
// rudder and throttle positions after that tick. A tick passes through an input register
// and then one combinational update into the result register, which also holds the four
// positions as state, so a tick can be accepted every cycle while m_tready is high. Its
// result is registered from the input register, which keeps accepting while a finished
// result waits on m_tready, until both stages are full. The longest path is the roll
// error divided by three (one 14 by 16 bit multiply) into the aileron clamp. Configuration
// writes are taken on any cycle but are meant to happen only while no tick is in flight.
`timescale 1ns / 1ps

module flight_control_input_shaper_core (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // key_up, key_pitch_down, key_roll_left, key_roll_right, key_yaw_plus, key_yaw_minus,
    // key_throttle_up, key_throttle_down, other_key_held, pitch_tenths[10:0],
    // roll_tenths[11:0]
    input  logic [fcis_pkg::IN_DATA_W-1:0]        s_tdata,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // elevator_out[8:0], aileron_out[8:0], rudder_out[8:0], throttle_out[7:0], zero pad
    output logic [fcis_pkg::OUT_DATA_W-1:0]       m_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    input  logic                                  cfg_wr_en,
    input  logic [fcis_pkg::CFG_IDX_W-1:0]        cfg_wr_index,
    input  logic [fcis_pkg::CFG_DATA_W-1:0]       cfg_wr_data
);
    import fcis_pkg::*;

    logic                             autopilot_enable_reg;
    logic signed [PITCH_W-1:0]        target_pitch_reg;
    logic signed [ROLL_W-1:0]         target_roll_reg;

    logic                             in_valid_reg;
    in_item_t                         in_item_reg;
    logic                             out_valid_reg;

    logic signed [AXIS_W-1:0]         elevator_pos_reg;
    logic signed [AXIS_W-1:0]         aileron_pos_reg;
    logic signed [AXIS_W-1:0]         rudder_pos_reg;
    logic        [THROTTLE_W-1:0]     throttle_pos_reg;

    logic signed [AXIS_W-1:0]         elevator_pos_next;
    logic signed [AXIS_W-1:0]         aileron_pos_next;
    logic signed [AXIS_W-1:0]         rudder_pos_next;
    logic        [THROTTLE_W-1:0]     throttle_pos_next;

    logic signed [AXIS_W-1:0]         elevator_manual;
    logic signed [AXIS_W-1:0]         aileron_manual;
    logic signed [AXIS_W-1:0]         elevator_auto;
    logic signed [AXIS_W-1:0]         aileron_auto;
    logic signed [9:0]                throttle_sum;

    axis_keys_t                       elevator_keys;
    axis_keys_t                       aileron_keys;
    axis_keys_t                       rudder_keys;

    logic                             any_key;
    logic                             autopilot_active;
    logic                             advance;
    logic                             s_xfer;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_xfer   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W-3*AXIS_W-THROTTLE_W){1'b0}}, throttle_pos_reg,
                       rudder_pos_reg, aileron_pos_reg, elevator_pos_reg};

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            autopilot_enable_reg <= 1'b0;
            target_pitch_reg     <= TARGET_PITCH_RESET;
            target_roll_reg      <= TARGET_ROLL_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                CFG_AUTOPILOT_ENABLE: autopilot_enable_reg <= cfg_wr_data[0];
                CFG_TARGET_PITCH:     target_pitch_reg     <= cfg_wr_data[PITCH_W-1:0];
                CFG_TARGET_ROLL:      target_roll_reg      <= cfg_wr_data[ROLL_W-1:0];
                default: ;
            endcase
        end
    end

    // input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            in_item_reg <= in_item_t'(s_tdata);
        end
    end

    assign elevator_keys = '{first: in_item_reg.key_up, second: in_item_reg.key_pitch_down,
                             first_down: 1'b0};
    // left lowers the aileron and wins over right
    assign aileron_keys  = '{first: in_item_reg.key_roll_left,
                             second: in_item_reg.key_roll_right, first_down: 1'b1};
    assign rudder_keys   = '{first: in_item_reg.key_yaw_plus,
                             second: in_item_reg.key_yaw_minus, first_down: 1'b0};

    fcis_axis u_elevator (
        .keys     (elevator_keys),
        .pos      (elevator_pos_reg),
        .pos_next (elevator_manual)
    );

    fcis_axis u_aileron (
        .keys     (aileron_keys),
        .pos      (aileron_pos_reg),
        .pos_next (aileron_manual)
    );

    fcis_axis u_rudder (
        .keys     (rudder_keys),
        .pos      (rudder_pos_reg),
        .pos_next (rudder_pos_next)
    );

    fcis_autopilot u_autopilot (
        .pitch_tenths (in_item_reg.pitch_tenths),
        .roll_tenths  (in_item_reg.roll_tenths),
        .target_pitch (target_pitch_reg),
        .target_roll  (target_roll_reg),
        .elevator_cmd (elevator_auto),
        .aileron_cmd  (aileron_auto)
    );

    assign any_key = in_item_reg.key_up || in_item_reg.key_pitch_down
                  || in_item_reg.key_roll_left || in_item_reg.key_roll_right
                  || in_item_reg.key_yaw_plus
                  || in_item_reg.key_yaw_minus || in_item_reg.key_throttle_up
                  || in_item_reg.key_throttle_down || in_item_reg.other_key_held;
    assign autopilot_active = autopilot_enable_reg && !any_key;

    assign elevator_pos_next = autopilot_active ? elevator_auto : elevator_manual;
    assign aileron_pos_next  = autopilot_active ? aileron_auto  : aileron_manual;

    assign throttle_sum = $signed({2'b00, throttle_pos_reg})
                        + (in_item_reg.key_throttle_up   ? 10'(THROTTLE_STEP) : 10'sd0)
                        - (in_item_reg.key_throttle_down ? 10'(THROTTLE_STEP) : 10'sd0);
    assign throttle_pos_next = clamp_throttle(throttle_sum);

    // result register doubles as the control position state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg    <= 1'b0;
            elevator_pos_reg <= '0;
            aileron_pos_reg  <= '0;
            rudder_pos_reg   <= '0;
            throttle_pos_reg <= '0;
        end else begin
            if (advance) begin
                out_valid_reg    <= 1'b1;
                elevator_pos_reg <= elevator_pos_next;
                aileron_pos_reg  <= aileron_pos_next;
                rudder_pos_reg   <= rudder_pos_next;
                throttle_pos_reg <= throttle_pos_next;
            end else if (m_tready) begin
                out_valid_reg    <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    a_state_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable({elevator_pos_reg, aileron_pos_reg, rudder_pos_reg,
                              throttle_pos_reg}))
        else $error("control state changed without a tick");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_tvalid)
        else $error("tick processed but no result presented");

    a_axis_range: assert property (@(posedge aclk) disable iff (!aresetn)
        elevator_pos_reg >= -9'sd200 && elevator_pos_reg <= 9'sd200 &&
        aileron_pos_reg >= -9'sd200 && aileron_pos_reg <= 9'sd200 &&
        rudder_pos_reg >= -9'sd200 && rudder_pos_reg <= 9'sd200)
        else $error("axis position outside its limits");

    a_throttle_range: assert property (@(posedge aclk) disable iff (!aresetn)
        throttle_pos_reg <= 8'(THROTTLE_LIMIT))
        else $error("throttle position above its limit");
`endif

endmodule
